// File: rtl/vrt_pkg.sv
// Shared types and constants for the voxel ray traversal block.
package vrt_pkg;

   localparam int TW = 24;
   localparam logic [TW-1:0] T_ONES = {TW{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DIV,
      ST_INIT,
      ST_READ,
      ST_TEST,
      ST_STEP,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      AXIS_NONE = 2'd0,
      AXIS_X    = 2'd1,
      AXIS_Y    = 2'd2,
      AXIS_Z    = 2'd3
   } axis_type;

endpackage

// File: rtl/vrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module vrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/vrt_div.sv
// Restoring divider computing the saturated reciprocal 2^(F+14) / m, one bit a cycle.
module vrt_div #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [23:0]           mag,
   output logic                  done,
   output logic [vrt_pkg::TW-1:0] quot
);

   localparam int NB = FRACTION_BITS + 15;
   localparam int CW = $clog2(NB + 1);

   logic [NB-1:0] num_ff, num_in;
   logic [NB:0]   rem_ff, rem_in;
   logic [23:0]   den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [NB:0]   trial;
   logic [NB:0]   shifted;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff[NB-1:0], num_ff[NB-1]};
      trial   = shifted - {{(NB-23){1'b0}}, den_ff};
      if (start) begin
         num_in = {1'b1, {(NB-1){1'b0}}};
         rem_in = '0;
         den_in = mag;
         cnt_in = CW'(NB - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[NB-2:0], 1'b0};
         if (!trial[NB]) begin
            rem_in = trial;
            num_in[0] = 1'b1;
         end else begin
            rem_in = shifted;
         end
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // The numerator bits are shifted out at the top while quotient bits enter at the bottom.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = (den_ff == '0 || |num_ff[NB-1:vrt_pkg::TW]) ? vrt_pkg::T_ONES
                                                           : num_ff[vrt_pkg::TW-1:0];

endmodule

// File: rtl/voxel_ray_traversal.sv
// Top level of the voxel ray traversal block: voxel memory, reciprocal unit and grid walker.
// After reset a clearing pass writes air to every voxel, during which no beat is accepted.
// A write beat gives no result. A cast runs three reciprocal divisions, each followed by a
// state that sets the first boundary time for its axis, then per voxel visited one memory read,
// one test and one step. One cast at a time; the result register lets the next beat in.
module voxel_ray_traversal #(
   parameter int GRID_SIZE     = 32,
   parameter int BLOCK_ID_BITS = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_type,
   input  logic [4:0]               req_voxel_x,
   input  logic [4:0]               req_voxel_y,
   input  logic [4:0]               req_voxel_z,
   input  logic [BLOCK_ID_BITS-1:0] req_block_value,
   input  logic signed [23:0]       req_start_x,
   input  logic signed [23:0]       req_start_y,
   input  logic signed [23:0]       req_start_z,
   input  logic signed [15:0]       req_dir_x,
   input  logic signed [15:0]       req_dir_y,
   input  logic signed [15:0]       req_dir_z,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_hit,
   output logic [4:0]               rsp_hit_x,
   output logic [4:0]               rsp_hit_y,
   output logic [4:0]               rsp_hit_z,
   output logic [7:0]               rsp_hit_block,
   output logic [1:0]               rsp_face_axis,
   output logic                     rsp_face_negative,
   input  logic                     csr_we,
   input  logic [7:0]               csr_wdata
);

   localparam int TW    = vrt_pkg::TW;
   localparam int GB    = $clog2(GRID_SIZE);
   localparam int CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
   localparam int AB    = 3 * GB;
   // The walk can run several hundred voxels past the start, so positions get headroom.
   localparam int PW    = 24 - FRACTION_BITS + 11;
   localparam logic [TW:0] T_ONE = (TW+1)'(1) << FRACTION_BITS;

   vrt_pkg::state_type state_ff, state_in;

   logic [7:0]          dist_ff;
   logic [AB:0]         clr_ff, clr_in;
   logic signed [PW-1:0] pos_ff [3];
   logic signed [PW-1:0] pos_in [3];
   logic [TW-1:0]       tnext_ff [3];
   logic [TW-1:0]       tnext_in [3];
   logic [TW-1:0]       tstep_ff [3];
   logic [TW-1:0]       tstep_in [3];
   logic signed [15:0]  dir_y_ff, dir_y_in, dir_z_ff, dir_z_in;
   logic [2:0]          pos_dir_ff, pos_dir_in;
   logic [2:0]          neg_dir_ff, neg_dir_in;
   logic [FRACTION_BITS-1:0] frac_ff [3];
   logic [FRACTION_BITS-1:0] frac_in [3];
   logic [1:0]          axis_ff, axis_in;
   logic [1:0]          last_ff, last_in;
   logic                oob_ff, oob_in;

   logic                out_valid_ff, out_valid_in;
   logic                out_hit_ff, out_hit_in;
   logic [4:0]          out_x_ff, out_x_in, out_y_ff, out_y_in, out_z_ff, out_z_in;
   logic [7:0]          out_blk_ff, out_blk_in;
   logic [1:0]          out_fa_ff, out_fa_in;
   logic                out_fn_ff, out_fn_in;

   logic                accept;
   logic                ram_we;
   logic [AB-1:0]       ram_waddr, ram_raddr;
   logic [BLOCK_ID_BITS-1:0] ram_wdata, ram_rdata;

   logic                div_start;
   logic                div_done;
   logic [23:0]         div_mag;
   logic [TW-1:0]       div_quot;
   logic signed [15:0]  dir_sel;
   logic [15:0]         dir_abs;
   logic [TW+FRACTION_BITS:0] prod;
   logic [FRACTION_BITS:0]    fmul;
   logic [TW:0]         tsum;
   logic [1:0]          ax;
   logic                all_out;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= 8'd8;
      end else if (csr_we) begin
         dist_ff <= csr_wdata;
      end
   end

   // A waiting result does not block the input; a finished walk waits for it instead.
   assign req_ready = (state_ff == vrt_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   vrt_ram #(.WIDTH(BLOCK_ID_BITS), .DEPTH(CELLS)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The voxel index packs x in the low bits, then y, then z.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = {GB'(req_voxel_z), GB'(req_voxel_y), GB'(req_voxel_x)};
      ram_wdata = req_block_value;
      if (state_ff == vrt_pkg::ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff[AB-1:0];
         ram_wdata = '0;
      end else if (accept && !req_type) begin
         ram_we = (int'(req_voxel_x) < GRID_SIZE) && (int'(req_voxel_y) < GRID_SIZE)
                  && (int'(req_voxel_z) < GRID_SIZE);
      end
      ram_raddr = {pos_ff[2][GB-1:0], pos_ff[1][GB-1:0], pos_ff[0][GB-1:0]};
   end

   // Divisor |dir| * reach for the axis whose division starts this cycle: x straight
   // from the accepted beat, y and z from the held copies of the direction.
   always_comb begin
      if (state_ff == vrt_pkg::ST_IDLE) begin
         dir_sel = req_dir_x;
      end else if (axis_ff == 2'd0) begin
         dir_sel = dir_y_ff;
      end else begin
         dir_sel = dir_z_ff;
      end
      dir_abs = dir_sel[15] ? 16'(-dir_sel) : dir_sel;
      div_mag = 24'(dir_abs) * 24'(dist_ff);
   end

   vrt_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   (div_mag),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Step axis by strict comparisons, ties toward z then y.
   always_comb begin
      if (tnext_ff[0] < tnext_ff[1]) begin
         ax = (tnext_ff[0] < tnext_ff[2]) ? 2'd0 : 2'd2;
      end else begin
         ax = (tnext_ff[1] < tnext_ff[2]) ? 2'd1 : 2'd2;
      end
      tsum = {1'b0, tnext_ff[ax]} + {1'b0, tstep_ff[ax]};
      fmul = pos_dir_ff[axis_ff] ? (T_ONE[FRACTION_BITS:0] - {1'b0, frac_ff[axis_ff]})
                                 : {1'b0, frac_ff[axis_ff]};
      prod = tstep_ff[axis_ff] * fmul;
      all_out = ({1'b0, tnext_ff[0]} > T_ONE) && ({1'b0, tnext_ff[1]} > T_ONE)
                && ({1'b0, tnext_ff[2]} > T_ONE);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vrt_pkg::ST_CLEAR: if (clr_ff == (AB+1)'(CELLS - 1)) state_in = vrt_pkg::ST_IDLE;
         vrt_pkg::ST_IDLE:  if (accept && req_type) state_in = vrt_pkg::ST_DIV;
         vrt_pkg::ST_DIV:   if (div_done) state_in = vrt_pkg::ST_INIT;
         vrt_pkg::ST_INIT:  state_in = (axis_ff == 2'd2) ? vrt_pkg::ST_READ : vrt_pkg::ST_DIV;
         vrt_pkg::ST_READ: begin
            // A miss ends the walk after the step that pushes every t beyond one, once no result waits.
            if (last_ff != vrt_pkg::AXIS_NONE && all_out) begin
               state_in = out_valid_ff ? vrt_pkg::ST_READ : vrt_pkg::ST_IDLE;
            end else begin
               state_in = vrt_pkg::ST_TEST;
            end
         end
         vrt_pkg::ST_TEST: begin
            if (!oob_ff && ram_rdata != '0) state_in = vrt_pkg::ST_DONE;
            else state_in = vrt_pkg::ST_STEP;
         end
         vrt_pkg::ST_STEP:  state_in = vrt_pkg::ST_READ;
         vrt_pkg::ST_DONE:  if (!out_valid_ff) state_in = vrt_pkg::ST_IDLE;
         default:           state_in = vrt_pkg::ST_IDLE;
      endcase
   end

   // Datapath updates.
   always_comb begin
      clr_in      = clr_ff;
      axis_in     = axis_ff;
      last_in     = last_ff;
      pos_dir_in  = pos_dir_ff;
      neg_dir_in  = neg_dir_ff;
      dir_y_in    = dir_y_ff;
      dir_z_in    = dir_z_ff;
      div_start   = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_hit_in  = out_hit_ff;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_z_in    = out_z_ff;
      out_blk_in  = out_blk_ff;
      out_fa_in   = out_fa_ff;
      out_fn_in   = out_fn_ff;
      for (int i = 0; i < 3; i++) begin
         pos_in[i]   = pos_ff[i];
         tnext_in[i] = tnext_ff[i];
         tstep_in[i] = tstep_ff[i];
         frac_in[i]  = frac_ff[i];
      end
      oob_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (pos_ff[i] < 0 || pos_ff[i] >= PW'(GRID_SIZE)) oob_in = 1'b1;
      end
      case (state_ff)
         vrt_pkg::ST_CLEAR: clr_in = clr_ff + 1'b1;
         vrt_pkg::ST_IDLE: begin
            if (accept && req_type) begin
               axis_in = 2'd0;
               last_in = vrt_pkg::AXIS_NONE;
               div_start = 1'b1;
               pos_in[0] = PW'(req_start_x >>> FRACTION_BITS);
               pos_in[1] = PW'(req_start_y >>> FRACTION_BITS);
               pos_in[2] = PW'(req_start_z >>> FRACTION_BITS);
               frac_in[0] = req_start_x[FRACTION_BITS-1:0];
               frac_in[1] = req_start_y[FRACTION_BITS-1:0];
               frac_in[2] = req_start_z[FRACTION_BITS-1:0];
               dir_y_in = req_dir_y;
               dir_z_in = req_dir_z;
               pos_dir_in = {req_dir_z > 0, req_dir_y > 0, req_dir_x > 0};
               neg_dir_in = {req_dir_z < 0, req_dir_y < 0, req_dir_x < 0};
            end
         end
         vrt_pkg::ST_DIV: if (div_done) tstep_in[axis_ff] = div_quot;
         vrt_pkg::ST_INIT: begin
            tnext_in[axis_ff] = (|prod[TW+FRACTION_BITS:TW+FRACTION_BITS]) ? vrt_pkg::T_ONES
                                : prod[TW+FRACTION_BITS-1:FRACTION_BITS];
            if (axis_ff != 2'd2) begin
               axis_in = axis_ff + 1'b1;
               div_start = 1'b1;
            end
         end
         vrt_pkg::ST_STEP: begin
            if (pos_dir_ff[ax]) pos_in[ax] = pos_ff[ax] + 1'b1;
            else if (neg_dir_ff[ax]) pos_in[ax] = pos_ff[ax] - 1'b1;
            tnext_in[ax] = tsum[TW] ? vrt_pkg::T_ONES : tsum[TW-1:0];
            last_in = ax + 1'b1;
         end
         default: ;
      endcase
      // A miss is known right after the step that pushes every t beyond one.
      if (state_ff == vrt_pkg::ST_READ && last_ff != vrt_pkg::AXIS_NONE && all_out
          && !out_valid_ff) begin
         out_valid_in = 1'b1;
         out_hit_in   = 1'b0;
         out_x_in     = '0;
         out_y_in     = '0;
         out_z_in     = '0;
         out_blk_in   = '0;
         out_fa_in    = vrt_pkg::AXIS_NONE;
         out_fn_in    = 1'b0;
      end
      // The read port keeps returning the hit voxel while the walker waits here.
      if (state_ff == vrt_pkg::ST_DONE && !out_valid_ff) begin
         out_valid_in = 1'b1;
         out_hit_in = 1'b1;
         out_x_in   = 5'(pos_ff[0]);
         out_y_in   = 5'(pos_ff[1]);
         out_z_in   = 5'(pos_ff[2]);
         out_blk_in = 8'(ram_rdata);
         out_fa_in  = last_ff;
         out_fn_in  = (last_ff != vrt_pkg::AXIS_NONE) && pos_dir_ff[last_ff - 1'b1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vrt_pkg::ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
      axis_ff    <= axis_in;
      last_ff    <= last_in;
      pos_dir_ff <= pos_dir_in;
      neg_dir_ff <= neg_dir_in;
      dir_y_ff   <= dir_y_in;
      dir_z_ff   <= dir_z_in;
      oob_ff     <= oob_in;
      for (int i = 0; i < 3; i++) begin
         pos_ff[i]   <= pos_in[i];
         tnext_ff[i] <= tnext_in[i];
         tstep_ff[i] <= tstep_in[i];
         frac_ff[i]  <= frac_in[i];
      end
      out_hit_ff <= out_hit_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_z_ff   <= out_z_in;
      out_blk_ff <= out_blk_in;
      out_fa_ff  <= out_fa_in;
      out_fn_ff  <= out_fn_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_hit           = out_hit_ff;
   assign rsp_hit_x         = out_x_ff;
   assign rsp_hit_y         = out_y_ff;
   assign rsp_hit_z         = out_z_ff;
   assign rsp_hit_block     = out_blk_ff;
   assign rsp_face_axis     = out_fa_ff;
   assign rsp_face_negative = out_fn_ff;

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == vrt_pkg::ST_IDLE)
      else $error("ready outside idle");
   a_no_write_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vrt_pkg::ST_STEP) |-> !ram_we)
      else $error("memory write during walk");
   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> rsp_hit_block != '0)
      else $error("hit with air block");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_face_axis == vrt_pkg::AXIS_NONE && !rsp_face_negative))
      else $error("miss with face");
`endif

endmodule

// File: bench/tb_voxel_ray_traversal.sv
// Self-checking testbench for the voxel ray traversal block: writes voxels, casts rays, compares hits.
module tb_voxel_ray_traversal;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID = 32;
   localparam int FRAC = 16;
   localparam logic [23:0] T_ONE = 24'h010000;
   localparam int WATCHDOG_LIMIT = 200000;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_CAST  = 1'b1;

   // One result beat as the block presents it.
   typedef struct packed {
      logic       hit;
      logic [4:0] x;
      logic [4:0] y;
      logic [4:0] z;
      logic [7:0] block;
      vrt_pkg::axis_type face;
      logic       negative;
   } hit_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = REQ_WRITE;
   logic [4:0] req_voxel_x = '0, req_voxel_y = '0, req_voxel_z = '0;
   logic [7:0] req_block_value = '0;
   logic signed [23:0] req_start_x = '0, req_start_y = '0, req_start_z = '0;
   logic signed [15:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   logic [4:0] rsp_hit_x, rsp_hit_y, rsp_hit_z;
   logic [7:0] rsp_hit_block;
   logic [1:0] rsp_face_axis;
   logic rsp_face_negative;
   logic csr_we = 1'b0;
   logic [7:0] csr_wdata = '0;

   // Predictor state: its own copy of the grid and the reach register.
   logic [7:0] grid_model [GRID*GRID*GRID];
   logic [7:0] reach = 8'd8;
   hit_report_type expected_hits[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   bit receiver_hold = 1'b0;
   int error_count = 0;
   int beats_sent = 0;
   int casts_sent = 0;
   int results_seen = 0;
   int hits_seen = 0;
   int idle_cycles = 0;

   voxel_ray_traversal u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_voxel_x(req_voxel_x), .req_voxel_y(req_voxel_y), .req_voxel_z(req_voxel_z),
      .req_block_value(req_block_value),
      .req_start_x(req_start_x), .req_start_y(req_start_y), .req_start_z(req_start_z),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_hit_x(rsp_hit_x), .rsp_hit_y(rsp_hit_y), .rsp_hit_z(rsp_hit_z),
      .rsp_hit_block(rsp_hit_block), .rsp_face_axis(rsp_face_axis),
      .rsp_face_negative(rsp_face_negative),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // 4 ns clock period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Saturate a wide t value to the 24-bit all-ones ceiling.
   function automatic logic [23:0] saturate_t(logic [63:0] v);
      return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
   endfunction

   // Walks the grid the way the block does and returns the hit report for one ray.
   function automatic hit_report_type trace_ray(logic signed [23:0] s [3],
                                                logic signed [15:0] d [3]);
      hit_report_type r;
      int pos [3];
      int dirn [3];
      logic [23:0] t_next [3];
      logic [23:0] t_step [3];
      logic [63:0] mag;
      logic [63:0] frac;
      int ax;
      int last;
      logic [7:0] id;
      r = '0;
      for (int a = 0; a < 3; a++) begin
         frac = {48'd0, s[a][FRAC-1:0]};
         mag = (d[a] < 0) ? 64'(-int'(d[a])) : 64'(int'(d[a]));
         mag = mag * reach;
         pos[a] = int'(s[a]) >>> FRAC;
         dirn[a] = (d[a] > 0) ? 1 : ((d[a] < 0) ? -1 : 0);
         t_step[a] = (mag == 0) ? 24'hFFFFFF : saturate_t((64'd1 << (FRAC + 14)) / mag);
         if (dirn[a] > 0)
            t_next[a] = saturate_t((64'(t_step[a]) * (64'(T_ONE) - frac)) >> FRAC);
         else
            t_next[a] = saturate_t((64'(t_step[a]) * frac) >> FRAC);
      end
      last = 0;
      forever begin
         id = 8'd0;
         if (pos[0] >= 0 && pos[0] < GRID && pos[1] >= 0 && pos[1] < GRID &&
             pos[2] >= 0 && pos[2] < GRID)
            id = grid_model[pos[0] + pos[1] * GRID + pos[2] * GRID * GRID];
         if (id != 0) begin
            r.hit = 1'b1;
            r.x = pos[0][4:0];
            r.y = pos[1][4:0];
            r.z = pos[2][4:0];
            r.block = id;
            r.face = vrt_pkg::axis_type'(last[1:0]);
            r.negative = (last != 0) && (dirn[last-1] > 0);
            return r;
         end
         // Strict comparisons: ties fall through to y, then z.
         if (t_next[0] < t_next[1])
            ax = (t_next[0] < t_next[2]) ? 0 : 2;
         else
            ax = (t_next[1] < t_next[2]) ? 1 : 2;
         pos[ax] += dirn[ax];
         t_next[ax] = saturate_t(64'(t_next[ax]) + 64'(t_step[ax]));
         last = ax + 1;
         if (t_next[0] > T_ONE && t_next[1] > T_ONE && t_next[2] > T_ONE)
            return '0;
      end
   endfunction

   // Offers one beat and holds it until the block takes it, then updates the predictor.
   // Valid stays high after the handshake so a following beat can go back to back.
   task automatic send_beat(logic kind, logic [4:0] vx, logic [4:0] vy, logic [4:0] vz,
                            logic [7:0] blk, logic signed [23:0] s [3],
                            logic signed [15:0] d [3]);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_type <= kind;
      req_voxel_x <= vx;
      req_voxel_y <= vy;
      req_voxel_z <= vz;
      req_block_value <= blk;
      req_start_x <= s[0];
      req_start_y <= s[1];
      req_start_z <= s[2];
      req_dir_x <= d[0];
      req_dir_y <= d[1];
      req_dir_z <= d[2];
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      beats_sent++;
      if (kind == REQ_WRITE) begin
         grid_model[vx + vy * GRID + vz * GRID * GRID] = blk;
      end else begin
         casts_sent++;
         expected_hits.push_back(trace_ray(s, d));
      end
      @(negedge clock);
   endtask

   task automatic write_voxel(int x, int y, int z, int blk);
      logic signed [23:0] s [3];
      logic signed [15:0] d [3];
      s = '{24'($urandom), 24'($urandom), 24'($urandom)};
      d = '{16'($urandom), 16'($urandom), 16'($urandom)};
      send_beat(REQ_WRITE, x[4:0], y[4:0], z[4:0], blk[7:0], s, d);
   endtask

   task automatic cast_ray(int sx, int sy, int sz, int dx, int dy, int dz);
      logic signed [23:0] s [3];
      logic signed [15:0] d [3];
      s = '{sx[23:0], sy[23:0], sz[23:0]};
      d = '{dx[15:0], dy[15:0], dz[15:0]};
      send_beat(REQ_CAST, 5'($urandom), 5'($urandom), 5'($urandom), 8'($urandom), s, d);
   endtask

   // Waits for the result queue to drain, then lets a trailing write finish before a CSR write.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_hits.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_reach(logic [7:0] value);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      reach = value;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      $display("mismatch in %s: got %0d, expected %0d (result %0d)",
               what, got, want, results_seen);
   endtask

   // A random coordinate with FRAC fraction bits: mostly inside the grid, sometimes outside.
   function automatic int random_start();
      case ($urandom_range(9))
         0: return int'($urandom) >>> 8;
         1: return -int'($urandom_range(3 << FRAC));
         2: return int'($urandom_range(GRID << FRAC, (GRID + 3) << FRAC));
         3: return int'($urandom_range(GRID - 1)) << FRAC;
         default: return int'($urandom_range((GRID << FRAC) - 1));
      endcase
   endfunction

   function automatic int random_dir();
      case ($urandom_range(9))
         0: return 0;
         1: return $urandom_range(1) ? 16384 : -16384;
         2: return int'($urandom) >>> 16;
         default: return int'($urandom_range(32768)) - 16384;
      endcase
   endfunction

   // Directed part: corners of the fields, both request kinds and each special case.
   task automatic test_directed();
      write_voxel(5, 5, 5, 8'hFF);
      write_voxel(31, 31, 31, 1);
      write_voxel(0, 0, 0, 8'h80);
      write_voxel(9, 5, 5, 7);
      // Start inside a solid voxel reports no face.
      cast_ray(5 << FRAC, 5 << FRAC, 5 << FRAC, 16384, 0, 0);
      // Positive step along x hits the solid voxel at x = 9 through its negative face.
      cast_ray((6 << FRAC) + 1234, (5 << FRAC) + 32768, (5 << FRAC) + 32768, 16384, 0, 0);
      // Walking back toward the origin on each axis.
      cast_ray((3 << FRAC) + 100, 32768, 32768, -16384, 0, 0);
      cast_ray(32768, (3 << FRAC) + 100, 32768, 0, -16384, 0);
      cast_ray(32768, 32768, (3 << FRAC) + 100, 0, 0, -16384);
      // Zero direction with an exact integer start steps in place.
      cast_ray(6 << FRAC, 5 << FRAC, 5 << FRAC, 0, 0, 0);
      // Rays that start outside the grid or miss entirely.
      cast_ray(-(2 << FRAC), 31 << FRAC, 31 << FRAC, 16384, 0, 0);
      cast_ray(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16384, 16384, 16384);
      cast_ray(-8388608, -8388608, -8388608, -16384, -16384, -16384);
      // Directions out of the unit range.
      cast_ray(33 << FRAC, 33 << FRAC, 33 << FRAC, -32768, 32767, -32768);
      // Diagonal ties between axes.
      cast_ray(30 << FRAC, 30 << FRAC, 30 << FRAC, 9459, 9459, 9459);
      write_voxel(5, 5, 5, 0);
      cast_ray(5 << FRAC, 5 << FRAC, 5 << FRAC, 0, 0, 0);
   endtask

   // Random walk over the grid: mostly casts, the rest writes that furnish the scene.
   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 35)
            write_voxel($urandom_range(31), $urandom_range(31), $urandom_range(31),
                        $urandom_range(3) == 0 ? 0 : $urandom_range(255));
         else
            cast_ray(random_start(), random_start(), random_start(),
                     random_dir(), random_dir(), random_dir());
      end
   endtask

   // Receiver freezes while the sender keeps offering beats, so the input backs up.
   task automatic test_backpressure();
      receiver_hold = 1'b1;
      fork
         begin
            repeat (2000) @(negedge clock);
            receiver_hold = 1'b0;
         end
         test_random(20);
      join
   endtask

   task automatic test_reach_settings();
      logic [7:0] settings [4] = '{8'd1, 8'd255, 8'd0, 8'd37};
      foreach (settings[i]) begin
         set_reach(settings[i]);
         test_random(50);
      end
      set_reach(8'd8);
   endtask

   // Result checker: each beat is compared against the oldest prediction.
   always @(posedge clock) begin
      hit_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_hits.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            want = expected_hits.pop_front();
            if (rsp_hit) hits_seen++;
            if (rsp_hit != want.hit) report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_hit_x != want.x) report_mismatch("hit_x", rsp_hit_x, want.x);
            if (rsp_hit_y != want.y) report_mismatch("hit_y", rsp_hit_y, want.y);
            if (rsp_hit_z != want.z) report_mismatch("hit_z", rsp_hit_z, want.z);
            if (rsp_hit_block != want.block)
               report_mismatch("hit_block", rsp_hit_block, want.block);
            if (rsp_face_axis != want.face)
               report_mismatch("face_axis", rsp_face_axis, want.face);
            if (rsp_face_negative != want.negative)
               report_mismatch("face_negative", rsp_face_negative, want.negative);
         end
      end
   end

   // Receiver ready pattern, changed on the falling edge.
   always @(negedge clock)
      rsp_ready <= !receiver_hold && ($urandom_range(99) >= receiver_stall_pct);

   // Watchdog: counts cycles without any beat on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", expected_hits.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      foreach (grid_model[i]) grid_model[i] = 8'd0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_reach_settings();
      // Idling phases: none, sender sparse, receiver stalling, both.
      test_random(190);
      sender_idle_pct = 86;
      test_random(120);
      sender_idle_pct = 0;
      receiver_stall_pct = 86;
      test_random(120);
      sender_idle_pct = 19;
      receiver_stall_pct = 19;
      test_random(190);
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      test_backpressure();

      drain_results();
      repeat (200) @(negedge clock);
      $display("covered %0d beats (%0d casts, %0d results, %0d hits), five reach settings",
               beats_sent, casts_sent, results_seen, hits_seen);
      if (expected_hits.size() != 0)
         report_mismatch("results outstanding at end", 0, expected_hits.size());
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
